// ===== rtl/assert_macros.svh =====
// Assertion macros for the page cache RTL, included by lru_page_cache.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/lpc_pkg.sv =====
// Shared constants, types and sequencer states of the LRU page cache.
package lpc_pkg;

    localparam int ENTRIES     = 16;
    localparam int KEY_BITS    = 32;
    localparam int HANDLE_BITS = 32;
    localparam int CAP_BITS    = 5;
    localparam int IDX_BITS    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_BITS    = $clog2(ENTRIES + 1);
    localparam int AGE_BITS    = IDX_BITS;
    localparam int LINE_BITS   = KEY_BITS + HANDLE_BITS;

    typedef logic [IDX_BITS-1:0]    idx_t;
    typedef logic [CNT_BITS-1:0]    cnt_t;
    typedef logic [AGE_BITS-1:0]    age_t;
    typedef logic [KEY_BITS-1:0]    key_t;
    typedef logic [HANDLE_BITS-1:0] handle_t;
    typedef logic [CAP_BITS-1:0]    cap_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    // Recency update applied to all lanes together.
    typedef struct packed {
        logic en;        // apply the update
        idx_t slot;      // entry that becomes most recent
        age_t limit;     // entries younger than this age by one
        logic inc_all;   // age every valid entry regardless of limit
        logic set_valid; // mark the slot valid
    } age_cmd_t;

endpackage

// ===== rtl/lpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/lpc_age.sv =====
// Valid bits and recency ages of all cache entries, updated in all lanes together.
module lpc_age
    import lpc_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  age_cmd_t                      cmd,
    output logic [ENTRIES-1:0]            valid_vec,
    output logic [ENTRIES-1:0][AGE_BITS-1:0] age_vec
);

    logic [ENTRIES-1:0]               valid_reg, valid_next;
    logic [ENTRIES-1:0][AGE_BITS-1:0] age_reg, age_next;

    always_comb begin
        valid_next = valid_reg;
        age_next   = age_reg;
        if (cmd.en) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (idx_t'(i) == cmd.slot) begin
                    age_next[i]   = '0;
                    valid_next[i] = valid_reg[i] | cmd.set_valid;
                end else if (valid_reg[i] && (cmd.inc_all || age_reg[i] < cmd.limit)) begin
                    age_next[i] = age_reg[i] + age_t'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
        age_reg <= age_next;
    end

    assign valid_vec = valid_reg;
    assign age_vec   = age_reg;

endmodule

// ===== rtl/lru_page_cache.sv =====
// Top level of the fully associative LRU page cache.
//
// Usage: a request on the s_ channel carries a page key and the handle the
// slow store would return for it. One result per request leaves on the m_
// channel: hit flag, page handle (stored one on a hit, fill handle on a
// miss), and the key of the entry evicted to make room, if any.
// Operation: a single compare unit walks the entries one per cycle through
// the key/handle RAM read port, then the commit state updates recency and,
// on a miss, writes the RAM; the commit also loads the output register.
// A request passes through scan and commit, and the sequencer returns to
// idle with s_ready high before it takes the next request.
// s_ready is high only while the sequencer is idle, so one request is in
// flight at a time; the next request may be taken while a result waits.
// Stall: while a result waits and m_ready is low, the commit holds until
// the output register frees up, so no result is lost or overwritten.
// Reset (aresetn, synchronous, active low): all entries invalid, occupancy
// zero, capacity back to ENTRIES. No clearing pass is needed.
// Configuration: cfg_we writes cfg_wdata into capacity; write only while idle.
`include "assert_macros.svh"

module lru_page_cache
    import lpc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // capacity register
    input  logic                   cfg_we,
    input  logic [CAP_BITS-1:0]    cfg_wdata,
    // request channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [KEY_BITS-1:0]    s_page_key,
    input  logic [HANDLE_BITS-1:0] s_fill_handle,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_hit,
    output logic [HANDLE_BITS-1:0] m_page_handle,
    output logic                   m_evicted,
    output logic [KEY_BITS-1:0]    m_evicted_key
);

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    state_t  state_reg, state_next;
    cap_t    capacity_reg, capacity_next;
    cnt_t    used_count_reg, used_count_next;

    // captured request
    key_t    req_key_reg, req_key_next;
    handle_t req_fill_reg, req_fill_next;

    // scan address counter and read pipeline
    cnt_t    scan_idx_reg, scan_idx_next;
    logic    rd_vld_reg, rd_vld_next;
    idx_t    rd_idx_reg, rd_idx_next;

    // scan results
    logic    found_reg, found_next;
    idx_t    hit_idx_reg, hit_idx_next;
    age_t    hit_age_reg, hit_age_next;
    handle_t hit_handle_reg, hit_handle_next;
    logic    any_reg, any_next;
    idx_t    best_idx_reg, best_idx_next;
    age_t    best_age_reg, best_age_next;
    key_t    best_key_reg, best_key_next;
    logic    free_found_reg, free_found_next;
    idx_t    free_idx_reg, free_idx_next;

    // output register
    logic    m_valid_reg, m_valid_next;
    logic    m_hit_reg, m_hit_next;
    handle_t m_handle_reg, m_handle_next;
    logic    m_evicted_reg, m_evicted_next;
    key_t    m_evkey_reg, m_evkey_next;

    // ---------------------------------------------------------------
    // Storage
    // ---------------------------------------------------------------
    logic                          ram_we;
    idx_t                          ram_raddr;
    logic [LINE_BITS-1:0]          ram_rdata;
    key_t                          ram_key;
    handle_t                       ram_handle;
    logic [ENTRIES-1:0]            valid_vec;
    logic [ENTRIES-1:0][AGE_BITS-1:0] age_vec;
    age_cmd_t                      age_cmd;

    // sequencer outputs
    logic    scan_issue;
    logic    scan_last;
    logic    out_free;
    logic    commit;

    // commit decisions
    cnt_t    eff_cap;
    logic    full;
    logic    miss_evict;
    logic    miss_empty;
    logic    miss_fill;
    idx_t    commit_slot;

    // scan compare unit
    logic    cur_valid;
    age_t    cur_age;
    logic    cur_match;

    assign ram_key    = ram_rdata[LINE_BITS-1:HANDLE_BITS];
    assign ram_handle = ram_rdata[HANDLE_BITS-1:0];
    assign ram_raddr  = scan_idx_reg[IDX_BITS-1:0];

    lpc_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (ENTRIES)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (commit_slot),
        .wdata ({req_key_reg, req_fill_reg}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lpc_age u_age (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (age_cmd),
        .valid_vec (valid_vec),
        .age_vec   (age_vec)
    );

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    assign scan_last = rd_vld_reg && (rd_idx_reg == idx_t'(ENTRIES - 1));
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs
    // ---------------------------------------------------------------
    always_comb begin
        s_ready    = 1'b0;
        scan_issue = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_ready    = 1'b1;
            ST_SCAN:   scan_issue = (scan_idx_reg < cnt_t'(ENTRIES));
            ST_COMMIT: commit     = out_free;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Scan: one entry per cycle through the shared compare unit
    // ---------------------------------------------------------------
    assign cur_valid = valid_vec[rd_idx_reg];
    assign cur_age   = age_vec[rd_idx_reg];
    assign cur_match = cur_valid && (ram_key == req_key_reg);

    always_comb begin
        req_key_next    = req_key_reg;
        req_fill_next   = req_fill_reg;
        scan_idx_next   = scan_idx_reg;
        rd_vld_next     = scan_issue;
        rd_idx_next     = ram_raddr;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_age_next    = hit_age_reg;
        hit_handle_next = hit_handle_reg;
        any_next        = any_reg;
        best_idx_next   = best_idx_reg;
        best_age_next   = best_age_reg;
        best_key_next   = best_key_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;

        if (s_valid && s_ready) begin
            // capture the request and clear the scan results
            req_key_next    = s_page_key;
            req_fill_next   = s_fill_handle;
            scan_idx_next   = '0;
            found_next      = 1'b0;
            any_next        = 1'b0;
            free_found_next = 1'b0;
        end else begin
            if (scan_issue) begin
                scan_idx_next = scan_idx_reg + cnt_t'(1);
            end
            if (rd_vld_reg) begin
                // keep the first matching entry
                if (cur_match && !found_reg) begin
                    found_next      = 1'b1;
                    hit_idx_next    = rd_idx_reg;
                    hit_age_next    = cur_age;
                    hit_handle_next = ram_handle;
                end
                // track the oldest valid entry, first one on a tie
                if (cur_valid && (!any_reg || cur_age > best_age_reg)) begin
                    any_next      = 1'b1;
                    best_idx_next = rd_idx_reg;
                    best_age_next = cur_age;
                    best_key_next = ram_key;
                end
                // remember the lowest free slot
                if (!cur_valid && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = rd_idx_reg;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Commit: recency update, RAM write, occupancy and result
    // ---------------------------------------------------------------
    always_comb begin
        // clamp capacity to 1..ENTRIES
        if (capacity_reg == '0) begin
            eff_cap = cnt_t'(1);
        end else if (CNT_BITS'(capacity_reg) > cnt_t'(ENTRIES)) begin
            eff_cap = cnt_t'(ENTRIES);
        end else begin
            eff_cap = cnt_t'(capacity_reg);
        end
    end

    assign full       = (used_count_reg >= eff_cap) || (used_count_reg >= cnt_t'(ENTRIES));
    assign miss_evict = !found_reg && full && any_reg;
    assign miss_empty = !found_reg && full && !any_reg;
    assign miss_fill  = !found_reg && !full;

    always_comb begin
        priority if (found_reg) begin
            commit_slot = hit_idx_reg;
        end else if (miss_evict) begin
            commit_slot = best_idx_reg;
        end else if (miss_fill) begin
            commit_slot = free_idx_reg;
        end else begin
            commit_slot = '0;
        end
    end

    always_comb begin
        age_cmd.en        = commit;
        age_cmd.slot      = commit_slot;
        age_cmd.limit     = found_reg ? hit_age_reg : best_age_reg;
        age_cmd.inc_all   = miss_fill;
        age_cmd.set_valid = !found_reg;
    end

    assign ram_we = commit && !found_reg;

    always_comb begin
        used_count_next = used_count_reg;
        capacity_next   = capacity_reg;
        if (cfg_we) begin
            capacity_next = cfg_wdata;
        end
        if (commit && miss_fill) begin
            used_count_next = used_count_reg + cnt_t'(1);
        end else if (commit && miss_empty) begin
            used_count_next = cnt_t'(1);
        end
    end

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_hit_next     = m_hit_reg;
        m_handle_next  = m_handle_reg;
        m_evicted_next = m_evicted_reg;
        m_evkey_next   = m_evkey_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (commit) begin
            m_valid_next   = 1'b1;
            m_hit_next     = found_reg;
            m_handle_next  = found_reg ? hit_handle_reg : req_fill_reg;
            m_evicted_next = miss_evict;
            m_evkey_next   = miss_evict ? best_key_reg : '0;
        end
    end

    // ---------------------------------------------------------------
    // Register update
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            capacity_reg   <= cap_t'(ENTRIES);
            used_count_reg <= '0;
            rd_vld_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            capacity_reg   <= capacity_next;
            used_count_reg <= used_count_next;
            rd_vld_reg     <= rd_vld_next;
            m_valid_reg    <= m_valid_next;
        end
        req_key_reg    <= req_key_next;
        req_fill_reg   <= req_fill_next;
        scan_idx_reg   <= scan_idx_next;
        rd_idx_reg     <= rd_idx_next;
        found_reg      <= found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_age_reg    <= hit_age_next;
        hit_handle_reg <= hit_handle_next;
        any_reg        <= any_next;
        best_idx_reg   <= best_idx_next;
        best_age_reg   <= best_age_next;
        best_key_reg   <= best_key_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        m_hit_reg      <= m_hit_next;
        m_handle_reg   <= m_handle_next;
        m_evicted_reg  <= m_evicted_next;
        m_evkey_reg    <= m_evkey_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_hit         = m_hit_reg;
    assign m_page_handle = m_handle_reg;
    assign m_evicted     = m_evicted_reg;
    assign m_evicted_key = m_evkey_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `ASSERT_ALWAYS(a_count_matches_valid, aclk, aresetn, $countones(valid_vec) == int'(used_count_reg), "occupancy count disagrees with valid bits")
    `ASSERT_ALWAYS(a_hit_never_evicts, aclk, aresetn, !(m_valid && m_hit && m_evicted), "hit result reports an eviction")
    `ASSERT_NEXT(a_accept_starts_scan, aclk, aresetn, s_valid && s_ready, state_reg == ST_SCAN && !m_valid_reg == !$past(m_valid_reg && !m_ready), "accepted request did not start a scan")
    `ASSERT_NEXT(a_miss_sets_valid, aclk, aresetn, commit && !found_reg, valid_vec[$past(commit_slot)] && age_vec[$past(commit_slot)] == '0, "filled slot not valid and most recent")

endmodule

// ===== sim/lru_page_cache_test.sv =====
// Self-checking testbench for the LRU page cache: queued requests, predictor, result checker.
`timescale 1ns / 100ps

module lru_page_cache_test;
    import lpc_pkg::*;

    // One request as the driver presents it.
    typedef struct packed {
        key_t    key;
        handle_t fill;
    } page_req_t;

    // One result as the cache should return it.
    typedef struct packed {
        logic    hit;
        handle_t page_handle;
        logic    evicted;
        key_t    evicted_key;
    } page_result_t;

    localparam int LONG_HOLD    = 400; // receiver hold-off, in cycles
    localparam int PHASES       = 8;   // random phases
    localparam int PHASE_ITEMS  = 219; // random requests per phase
    localparam int POOL_MAX     = 40;

    // DUT ports; every input starts at a known value.
    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CAP_BITS-1:0]    cfg_wdata     = '0;
    logic                   s_valid       = 1'b0;
    logic                   s_ready;
    logic [KEY_BITS-1:0]    s_page_key    = '0;
    logic [HANDLE_BITS-1:0] s_fill_handle = '0;
    logic                   m_valid;
    logic                   m_ready       = 1'b0;
    logic                   m_hit;
    logic [HANDLE_BITS-1:0] m_page_handle;
    logic                   m_evicted;
    logic [KEY_BITS-1:0]    m_evicted_key;

    // Request queue filled by the stimulus block, drained by the driver.
    page_req_t    pending_reqs[$];
    // Results the cache still owes, oldest first.
    page_result_t owed_results[$];

    int  queued_count   = 0; // requests handed to the driver
    int  taken_count    = 0; // requests the cache accepted
    int  fail_count     = 0;
    int  hit_total      = 0;
    int  evict_total    = 0;
    int  cap_settings   = 0;
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  long_hold_go   = 1'b0;
    logic req_taken     = 1'b0; // request accepted at the last rising edge

    // Predictor state: its own copy of the cache contents and the capacity.
    bit          line_valid [ENTRIES];
    key_t        line_key   [ENTRIES];
    handle_t     line_handle[ENTRIES];
    int unsigned line_age   [ENTRIES];
    int unsigned occupancy;
    cap_t        cap_reg;

    lru_page_cache u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_page_key    (s_page_key),
        .s_fill_handle (s_fill_handle),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_page_handle (m_page_handle),
        .m_evicted     (m_evicted),
        .m_evicted_key (m_evicted_key)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Hard stop in case the cache hangs.
    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Capacity as the cache uses it: zero acts as one, large values saturate.
    function automatic int unsigned usable_capacity(cap_t cap);
        if (cap == 0)
            return 1;
        if (cap > ENTRIES)
            return ENTRIES;
        return cap;
    endfunction

    // Make a slot most recent; valid entries younger than the limit age by one.
    function automatic void refresh_slot(int slot, int unsigned limit);
        for (int i = 0; i < ENTRIES; i++) begin
            if (i != slot && line_valid[i] && line_age[i] < limit)
                line_age[i]++;
        end
        line_age[slot] = 0;
    endfunction

    // Look up one page, update recency, fill on a miss, return the expected result.
    function automatic page_result_t access_page(key_t key, handle_t fill);
        page_result_t res;
        int           slot;
        int           victim;
        bit           found;
        bit           seen;
        res   = '0;
        slot  = 0;
        found = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!found && line_valid[i] && line_key[i] == key) begin
                slot  = i;
                found = 1'b1;
            end
        end
        if (found) begin
            refresh_slot(slot, line_age[slot]);
            res.hit         = 1'b1;
            res.page_handle = line_handle[slot];
            return res;
        end
        if (occupancy >= usable_capacity(cap_reg) || occupancy >= ENTRIES) begin
            // Full (or capacity lowered below occupancy): reuse the oldest slot, or slot 0 if none is valid.
            seen   = 1'b0;
            victim = 0;
            for (int i = 0; i < ENTRIES; i++) begin
                if (line_valid[i] && (!seen || line_age[i] > line_age[victim])) begin
                    victim = i;
                    seen   = 1'b1;
                end
            end
            if (seen) begin
                slot            = victim;
                res.evicted     = 1'b1;
                res.evicted_key = line_key[slot];
                refresh_slot(slot, line_age[slot]);
            end else begin
                slot          = 0;
                line_valid[0] = 1'b1;
                occupancy     = 1;
                line_age[0]   = 0;
            end
        end else begin
            // Room left: take the lowest free slot, everything else ages.
            for (int i = ENTRIES - 1; i >= 0; i--) begin
                if (!line_valid[i])
                    slot = i;
            end
            line_valid[slot] = 1'b1;
            occupancy++;
            refresh_slot(slot, 32'hFFFF_FFFF);
        end
        line_key[slot]    = key;
        line_handle[slot] = fill;
        res.page_handle   = fill;
        return res;
    endfunction

    // Driver: present queued requests at the falling edge; hold each until taken.
    always @(negedge aclk) begin : driver
        page_req_t next_req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !req_taken) begin
            // hold: the request on the bus has not been accepted yet
        end else if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_req       = pending_reqs.pop_front();
            s_valid       <= 1'b1;
            s_page_key    <= next_req.key;
            s_fill_handle <= next_req.fill;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off counted here.
    always @(negedge aclk) begin : receiver
        int  hold_left;
        bit  long_hold_done;
        if (!aresetn) begin
            m_ready        <= 1'b0;
            hold_left       = 0;
            long_hold_done  = 1'b0;
        end else if (hold_left > 0) begin
            m_ready  <= 1'b0;
            hold_left--;
        end else if (long_hold_go && !long_hold_done) begin
            m_ready        <= 1'b0;
            hold_left       = LONG_HOLD - 1;
            long_hold_done  = 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: check results, predict accepted requests, track capacity writes.
    always @(posedge aclk) begin : monitor
        page_result_t want;
        page_result_t fresh;
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                line_valid[i]  = 1'b0;
                line_key[i]    = '0;
                line_handle[i] = '0;
                line_age[i]    = 0;
            end
            occupancy  = 0;
            cap_reg    = cap_t'(ENTRIES);
            req_taken <= 1'b0;
        end else begin
            // Check the result first: it can never belong to this edge's request.
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    $error("result with no request outstanding: hit %0d handle %h",
                           m_hit, m_page_handle);
                    fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (m_hit !== want.hit) begin
                        $error("hit: expected %0d actual %0d", want.hit, m_hit);
                        fail_count++;
                    end
                    if (m_page_handle !== want.page_handle) begin
                        $error("page_handle: expected %h actual %h",
                               want.page_handle, m_page_handle);
                        fail_count++;
                    end
                    if (m_evicted !== want.evicted) begin
                        $error("evicted: expected %0d actual %0d", want.evicted, m_evicted);
                        fail_count++;
                    end
                    if (m_evicted_key !== want.evicted_key) begin
                        $error("evicted_key: expected %h actual %h",
                               want.evicted_key, m_evicted_key);
                        fail_count++;
                    end
                end
            end
            req_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                fresh = access_page(s_page_key, s_fill_handle);
                owed_results.push_back(fresh);
                hit_total   += fresh.hit;
                evict_total += fresh.evicted;
                taken_count++;
            end
            if (cfg_we)
                cap_reg = cfg_wdata;
        end
    end

    task automatic queue_request(key_t key, handle_t fill);
        pending_reqs.push_back('{key: key, fill: fill});
        queued_count++;
    endtask

    // Wait until every queued request is taken and every result has come back.
    task automatic drain_results();
        while (taken_count != queued_count || owed_results.size() != 0)
            @(negedge aclk);
    endtask

    // Write the capacity register; call only with the cache idle.
    task automatic write_capacity(cap_t value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        cap_settings++;
    endtask

    // Stimulus: directed corners, then random phases with locality in the keys.
    initial begin : stimulus
        key_t        key_pool[POOL_MAX];
        int          pool_n;
        int          pick;
        int unsigned cap_list[PHASES];
        cap_t        phase_cap;
        key_t        req_key;
        handle_t     req_fill;

        cap_list = '{16, 1, 0, 31, 8, 17, 4, 12};

        // Hold reset, then release it at a falling edge.
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset capacity: extreme keys and handles, then hits on both.
        queue_request(32'h0000_0000, 32'h0000_0000);
        queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(32'h0000_0000, 32'h1234_5678);
        queue_request(32'hFFFF_FFFF, 32'h0000_0000);
        drain_results();

        // Drop capacity below occupancy: each miss evicts just the oldest entry.
        write_capacity(cap_t'(1));
        queue_request(32'h0000_0005, 32'hA5A5_A5A5);
        queue_request(32'h0000_0005, 32'h5A5A_5A5A);
        queue_request(32'h0000_0000, 32'hDEAD_BEEF);
        drain_results();

        // Capacity zero behaves as one.
        write_capacity(cap_t'(0));
        queue_request(32'h0000_0007, 32'h0F0F_0F0F);
        queue_request(32'h0000_0007, 32'hF0F0_F0F0);
        drain_results();

        // Capacity above the entry count saturates: fill every slot, then evict.
        write_capacity(cap_t'(31));
        for (int i = 0; i < 15; i++)
            queue_request(key_t'(100 + i), $urandom);
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            phase_cap = (p >= 6) ? cap_t'($urandom_range(31)) : cap_t'(cap_list[p]);
            write_capacity(phase_cap);

            // Idle mix: none, sender idle, receiver stalling, both a little.
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            // Hold off the receiver once while the sender keeps pushing requests.
            if (p == 0)
                long_hold_go = 1'b1;

            // Working set around the capacity so hits, misses and evictions all occur.
            pool_n = $urandom_range(2 * usable_capacity(phase_cap) + 4, 2);
            if (pool_n > POOL_MAX)
                pool_n = POOL_MAX;
            for (int i = 0; i < pool_n; i++)
                key_pool[i] = $urandom;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < 8)
                    req_key = $urandom;
                else if (pick < 10)
                    req_key = pick[0] ? '1 : '0;
                else
                    req_key = key_pool[$urandom_range(pool_n - 1)];
                pick = $urandom_range(99);
                if (pick < 3)
                    req_fill = pick[0] ? '1 : '0;
                else
                    req_fill = $urandom;
                queue_request(req_key, req_fill);
            end
            drain_results();
        end

        // Let any stray result surface before the verdict.
        repeat (ENTRIES + 8) @(posedge aclk);

        $display("Run: %0d requests, %0d hits, %0d evictions, %0d capacity settings.",
                 taken_count, hit_total, evict_total, cap_settings);
        $display("Idle mixes: none, sender idle, receiver stall, both; one long hold-off.");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lpc_pkg.sv
rtl/lpc_ram.sv
rtl/lpc_age.sv
rtl/lru_page_cache.sv
sim/lru_page_cache_test.sv
